/* rtl/bgsa_pkg.sv */
package bgsa_pkg;

  // Group size and the widths that follow from it
  localparam int MAX_BATTERIES = 8;
  localparam int PCNT_W        = $clog2(MAX_BATTERIES + 1);
  localparam int PSUM_W        = $clog2(100 * MAX_BATTERIES + 1);

  // Field widths
  localparam int TYPE_W = 3;
  localparam int MODE_W = 2;
  localparam int PCT_W  = 8;
  localparam int THR_W  = 7;
  localparam int MINI_W = 17;
  localparam int RATI_W = 21;
  localparam int MINO_W = 21;
  localparam int RATO_W = 24;
  localparam int MASK_W = 5;

  // Digit-serial adder lane
  localparam int DIG_W  = 4;
  localparam int LANE_W = 24;
  localparam int N_DIG  = LANE_W / DIG_W;
  localparam int DCNT_W = $clog2(N_DIG + 1);

  // Saturation limits
  localparam logic [LANE_W-1:0] MINUTES_MAX = 24'h0F_FFFF;
  localparam logic [LANE_W-1:0] RATE_MAX    = 24'hFF_FFFF;

  // Threshold defaults
  localparam logic [THR_W-1:0] WARN_DEF = 7'd12;
  localparam logic [THR_W-1:0] LOW_DEF  = 7'd7;
  localparam logic [THR_W-1:0] CRIT_DEF = 7'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLL_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_THR  = 2'd3;

  // Charge modes
  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

  // Level states
  typedef enum logic [2:0] {
    LVL_NONE   = 3'd0,
    LVL_NORMAL = 3'd1,
    LVL_WARN   = 3'd2,
    LVL_LOW    = 3'd3,
    LVL_CRIT   = 3'd4
  } level_t;

  // Change mask bit positions
  localparam int CHG_MODE  = 0;
  localparam int CHG_PCT   = 1;
  localparam int CHG_MIN   = 2;
  localparam int CHG_COUNT = 3;
  localparam int CHG_RATE  = 4;

  // Control between the sequencer and a serial unit
  typedef struct packed {
    logic start;
    logic clr;
  } unit_ctl_t;

endpackage

/* rtl/bgsa_digit_acc.sv */
module bgsa_digit_acc (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bgsa_pkg::unit_ctl_t       ctl,
  input  logic [bgsa_pkg::LANE_W-1:0] min_opnd,
  input  logic [bgsa_pkg::LANE_W-1:0] rate_opnd,
  output logic [bgsa_pkg::MINO_W-1:0] acc_minutes,
  output logic [bgsa_pkg::RATO_W-1:0] acc_rate,
  output logic                      done
);
  import bgsa_pkg::*;

  logic [LANE_W-1:0] acc_min_r, acc_min_nxt;
  logic [LANE_W-1:0] acc_rate_r, acc_rate_nxt;
  logic [LANE_W-1:0] op_min_r, op_rate_r;
  logic              cy_min_r, cy_rate_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIG_W:0]    sum_min, sum_rate;

  // Add one digit of each lane, lowest digit first
  assign sum_min  = {1'b0, acc_min_r[DIG_W-1:0]} + {1'b0, op_min_r[DIG_W-1:0]}
                    + {{DIG_W{1'b0}}, cy_min_r};
  assign sum_rate = {1'b0, acc_rate_r[DIG_W-1:0]} + {1'b0, op_rate_r[DIG_W-1:0]}
                    + {{DIG_W{1'b0}}, cy_rate_r};

  // Rotate the sums; saturate once all digits are through
  always_comb begin
    acc_min_nxt  = {sum_min[DIG_W-1:0], acc_min_r[LANE_W-1:DIG_W]};
    acc_rate_nxt = {sum_rate[DIG_W-1:0], acc_rate_r[LANE_W-1:DIG_W]};
    if (cnt_r == DCNT_W'(N_DIG)) begin
      acc_min_nxt  = (acc_min_r > MINUTES_MAX) ? MINUTES_MAX : acc_min_r;
      acc_rate_nxt = cy_rate_r ? RATE_MAX : acc_rate_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_min_r  <= '0;
      acc_rate_r <= '0;
      busy_r     <= 1'b0;
      done_r     <= 1'b0;
      cnt_r      <= '0;
      cy_min_r   <= 1'b0;
      cy_rate_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.clr) begin
        acc_min_r  <= '0;
        acc_rate_r <= '0;
      end else if (ctl.start) begin
        op_min_r  <= min_opnd;
        op_rate_r <= rate_opnd;
        cy_min_r  <= 1'b0;
        cy_rate_r <= 1'b0;
        cnt_r     <= '0;
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        acc_min_r  <= acc_min_nxt;
        acc_rate_r <= acc_rate_nxt;
        if (cnt_r == DCNT_W'(N_DIG)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          op_min_r  <= op_min_r >> DIG_W;
          op_rate_r <= op_rate_r >> DIG_W;
          cy_min_r  <= sum_min[DIG_W];
          cy_rate_r <= sum_rate[DIG_W];
          cnt_r     <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign acc_minutes = acc_min_r[MINO_W-1:0];
  assign acc_rate    = acc_rate_r[RATO_W-1:0];
  assign done        = done_r;

endmodule

/* rtl/bgsa_div.sv */
module bgsa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bgsa_pkg::PSUM_W-1:0] dividend,
  input  logic [bgsa_pkg::PCNT_W-1:0] divisor,
  output logic [bgsa_pkg::PSUM_W-1:0] quotient,
  output logic                        done
);
  import bgsa_pkg::*;

  localparam int QCNT_W = $clog2(PSUM_W + 1);

  logic [PSUM_W-1:0] quo_r;
  logic [PCNT_W-1:0] rem_r, dvs_r;
  logic [PCNT_W:0]   rem_sh, rem_sub;
  logic [QCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic              q_bit;

  // One quotient bit per cycle, restoring
  assign rem_sh  = {rem_r, quo_r[PSUM_W-1]};
  assign q_bit   = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= QCNT_W'(PSUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[PSUM_W-2:0], q_bit};
        rem_r <= q_bit ? rem_sub[PCNT_W-1:0] : rem_sh[PCNT_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == QCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* rtl/battery_group_status_aggregator_core.sv */
// A report that does not take part is taken straight from the idle state; a matching one
// then passes through the 4-bit digit-serial minutes/rate adder. A last report then goes
// through bit-serial mean division before the result is published.
// No new report is taken while the adder or divider is busy (in_stall is high).
// The result sits in an output register, so the next report is taken while it waits.
// Reset (synchronous, rst_n low): accumulators clear, held values take their defaults.
module battery_group_status_aggregator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [bgsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgsa_pkg::THR_W-1:0]    cfg_data,
  // report channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_list_empty,
  input  logic [bgsa_pkg::TYPE_W-1:0]   in_battery_type,
  input  logic                          in_is_present,
  input  logic [bgsa_pkg::MODE_W-1:0]   in_battery_charge_mode,
  input  logic signed [bgsa_pkg::PCT_W-1:0]  in_battery_percent,
  input  logic signed [bgsa_pkg::MINI_W-1:0] in_battery_minutes,
  input  logic signed [bgsa_pkg::RATI_W-1:0] in_battery_rate,
  input  logic                          in_last_report,
  input  logic                          in_force_recheck,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_refresh_ok,
  output logic [bgsa_pkg::MODE_W-1:0]   out_group_charge_mode,
  output logic signed [bgsa_pkg::PCT_W-1:0]  out_group_percent,
  output logic signed [bgsa_pkg::MINO_W-1:0] out_group_minutes,
  output logic [bgsa_pkg::PCNT_W-1:0]   out_present_count,
  output logic [bgsa_pkg::RATO_W-1:0]   out_group_rate,
  output logic [2:0]                    out_level_state,
  output logic                          out_level_event,
  output logic [bgsa_pkg::MASK_W-1:0]   out_change_mask,
  output logic                          out_group_changed
);
  import bgsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_FIN,
    S_EMPTY
  } state_t;

  state_t state_r;

  // configuration
  logic [TYPE_W-1:0] coll_type_r;
  logic [THR_W-1:0]  warn_thr_r, low_thr_r, crit_thr_r;

  // accumulators kept here
  logic [PCNT_W-1:0] acc_present_r, acc_pvalid_r;
  logic [PSUM_W-1:0] acc_psum_r;
  logic [MODE_W-1:0] acc_mode_r;
  logic              last_r, force_r;

  // held values
  logic [MODE_W-1:0] held_mode_r;
  logic [PCT_W-1:0]  held_pct_r;
  logic [MINO_W-1:0] held_min_r;
  logic [PCNT_W-1:0] held_present_r;
  logic [RATO_W-1:0] held_rate_r;
  level_t            held_level_r;

  // output register
  logic              out_valid_r, out_ok_r, out_event_r;
  logic [MODE_W-1:0] out_mode_r;
  logic [PCT_W-1:0]  out_pct_r;
  logic [MINO_W-1:0] out_min_r;
  logic [PCNT_W-1:0] out_count_r;
  logic [RATO_W-1:0] out_rate_r;
  level_t            out_level_r;
  logic [MASK_W-1:0] out_mask_r;

  // serial units
  unit_ctl_t         acc_ctl;
  logic              acc_done, div_start, div_done;
  logic [MINO_W-1:0] acc_minutes;
  logic [RATO_W-1:0] acc_rate;
  logic [PSUM_W-1:0] div_q;

  logic              in_acc, match, out_free;
  logic [MODE_W-1:0] in_mode, merged_mode;
  logic [PCT_W-2:0]  in_pct_clamped;
  logic [LANE_W-1:0] min_opnd, rate_opnd;
  logic [THR_W-1:0]  mean;
  logic              pct_chg;
  level_t            target;
  logic [MASK_W-1:0] mask;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Qualify the report and merge its charge mode
  assign match = (in_battery_type == coll_type_r) && in_is_present
                 && (acc_present_r < PCNT_W'(MAX_BATTERIES));
  assign in_mode = (in_battery_charge_mode == MODE_INVALID) ? MODE_UNKNOWN
                                                            : in_battery_charge_mode;
  always_comb begin
    merged_mode = acc_mode_r;
    if (in_mode != acc_mode_r) begin
      if (acc_mode_r == MODE_UNKNOWN) merged_mode = in_mode;
      else if (in_mode != MODE_UNKNOWN) merged_mode = MODE_UNKNOWN;
    end
  end
  assign in_pct_clamped = (in_battery_percent > 8'sd100) ? 7'd100
                                                          : in_battery_percent[PCT_W-2:0];

  // Negative minutes or rate contribute nothing
  assign min_opnd  = in_battery_minutes[MINI_W-1] ? '0
                     : LANE_W'(in_battery_minutes[MINI_W-2:0]);
  assign rate_opnd = in_battery_rate[RATI_W-1] ? '0
                     : LANE_W'(in_battery_rate[RATI_W-2:0]);

  assign acc_ctl.start = in_acc && !in_list_empty && match;
  assign acc_ctl.clr   = ((state_r == S_FIN) && out_free) || (in_acc && in_list_empty);
  assign div_start     = ((state_r == S_ACC) && acc_done && last_r)
                         || (in_acc && !in_list_empty && !match && in_last_report);

  bgsa_digit_acc u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (acc_ctl),
    .min_opnd    (min_opnd),
    .rate_opnd   (rate_opnd),
    .acc_minutes (acc_minutes),
    .acc_rate    (acc_rate),
    .done        (acc_done)
  );

  bgsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_psum_r),
    .divisor  (acc_pvalid_r),
    .quotient (div_q),
    .done     (div_done)
  );

  // Classify the level from the mean
  assign mean    = (acc_pvalid_r == '0) ? '0 : div_q[THR_W-1:0];
  assign pct_chg = ({1'b0, mean} != held_pct_r) || force_r;
  always_comb begin
    if (acc_present_r == '0)             target = LVL_NONE;
    else if (mean <= crit_thr_r)         target = LVL_CRIT;
    else if (mean <= low_thr_r)          target = LVL_LOW;
    else if (mean <= warn_thr_r)         target = LVL_WARN;
    else if (held_level_r != LVL_NONE)   target = LVL_NORMAL;
    else                                 target = LVL_NONE;
  end
  always_comb begin
    mask            = '0;
    mask[CHG_MODE]  = acc_mode_r != held_mode_r;
    mask[CHG_PCT]   = pct_chg;
    mask[CHG_MIN]   = acc_minutes != held_min_r;
    mask[CHG_COUNT] = acc_present_r != held_present_r;
    mask[CHG_RATE]  = acc_rate != held_rate_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      coll_type_r    <= '0;
      warn_thr_r     <= WARN_DEF;
      low_thr_r      <= LOW_DEF;
      crit_thr_r     <= CRIT_DEF;
      acc_present_r  <= '0;
      acc_pvalid_r   <= '0;
      acc_psum_r     <= '0;
      acc_mode_r     <= MODE_UNKNOWN;
      last_r         <= 1'b0;
      force_r        <= 1'b0;
      held_mode_r    <= MODE_UNKNOWN;
      held_pct_r     <= '1;
      held_min_r     <= '1;
      held_present_r <= '0;
      held_rate_r    <= '0;
      held_level_r   <= LVL_NORMAL;
      out_valid_r    <= 1'b0;
    end else begin
      // drop the result once taken
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // configuration writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_COLL_TYPE: coll_type_r <= cfg_data[TYPE_W-1:0];
          CFG_WARN_THR:  warn_thr_r  <= cfg_data;
          CFG_LOW_THR:   low_thr_r   <= cfg_data;
          CFG_CRIT_THR:  crit_thr_r  <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            last_r  <= in_last_report;
            force_r <= in_force_recheck;
            if (in_list_empty) begin
              // restore defaults
              acc_present_r <= '0;
              acc_pvalid_r  <= '0;
              acc_psum_r    <= '0;
              acc_mode_r    <= MODE_UNKNOWN;
              held_mode_r   <= MODE_UNKNOWN;
              held_pct_r    <= '1;
              held_min_r    <= '1;
              held_rate_r   <= '0;
              held_level_r  <= LVL_NORMAL;
              warn_thr_r    <= WARN_DEF;
              low_thr_r     <= LOW_DEF;
              crit_thr_r    <= CRIT_DEF;
              state_r       <= S_EMPTY;
            end else if (match) begin
              acc_present_r <= acc_present_r + 1'b1;
              acc_mode_r    <= merged_mode;
              if (!in_battery_percent[PCT_W-1]) begin
                acc_psum_r   <= acc_psum_r + PSUM_W'(in_pct_clamped);
                acc_pvalid_r <= acc_pvalid_r + 1'b1;
              end
              state_r <= S_ACC;
            end else if (in_last_report) begin
              state_r <= S_DIV;
            end
          end
        end
        S_ACC: begin
          if (acc_done) state_r <= last_r ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done) state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            // publish, update held values and clear accumulators
            held_mode_r    <= acc_mode_r;
            held_min_r     <= acc_minutes;
            held_present_r <= acc_present_r;
            held_rate_r    <= acc_rate;
            if (pct_chg) begin
              held_pct_r   <= {1'b0, mean};
              held_level_r <= target;
            end
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b1;
            out_mode_r  <= acc_mode_r;
            out_pct_r   <= pct_chg ? {1'b0, mean} : held_pct_r;
            out_min_r   <= acc_minutes;
            out_count_r <= acc_present_r;
            out_rate_r  <= acc_rate;
            out_level_r <= pct_chg ? target : held_level_r;
            out_event_r <= pct_chg && (target != LVL_NONE) && (target != held_level_r);
            out_mask_r  <= mask;
            acc_present_r <= '0;
            acc_pvalid_r  <= '0;
            acc_psum_r    <= '0;
            acc_mode_r    <= MODE_UNKNOWN;
            state_r       <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= 1'b0;
            out_mode_r  <= held_mode_r;
            out_pct_r   <= held_pct_r;
            out_min_r   <= held_min_r;
            out_count_r <= held_present_r;
            out_rate_r  <= held_rate_r;
            out_level_r <= held_level_r;
            out_event_r <= 1'b0;
            out_mask_r  <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_refresh_ok        = out_ok_r;
  assign out_group_charge_mode = out_mode_r;
  assign out_group_percent     = out_pct_r;
  assign out_group_minutes     = out_min_r;
  assign out_present_count     = out_count_r;
  assign out_group_rate        = out_rate_r;
  assign out_level_state       = out_level_r;
  assign out_level_event       = out_event_r;
  assign out_change_mask       = out_mask_r;
  assign out_group_changed     = |out_mask_r[CHG_COUNT:CHG_MODE];

endmodule
